[sv/gll_pkg.sv]
// Shared types and constants for the GIF LZW pixel decoder.
package gll_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int BUF_W             = 24;
  localparam int HELD_W            = 5;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_FEED  = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_NEED    = 3'd1,
    ST_TAKEN   = 3'd2,
    ST_FULL    = 3'd3,
    ST_ENDCODE = 3'd4,
    ST_ENDDATA = 3'd5,
    ST_ERROR   = 3'd6
  } status_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
  } item_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_FIRST    = 5'b00010,
    S_POP      = 5'b00100,
    S_WALK_RD  = 5'b01000,
    S_WALK_USE = 5'b10000
  } state_t;

endpackage

[sv/gll_ram.sv]
// Generic single write port, single read port RAM with registered read.
module gll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/gll_front.sv]
// Input side: decodes the request kind and queues items for the decoder core.
module gll_front import gll_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output item_t      q_item
);

  item_t      q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      item;
  logic       push, pop;

  always_comb begin
    case (in_kind)
      CMD_START: item.cmd = CMD_START;
      CMD_FEED:  item.cmd = CMD_FEED;
      CMD_FETCH: item.cmd = CMD_FETCH;
      default:   item.cmd = CMD_END;
    endcase
    item.data_byte = in_byte;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= item;
    end
  end

endmodule

[sv/gll_back.sv]
// Decoder core: bit buffer, code reader, chain walk, tables and result register.
module gll_back import gll_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] min_code_size,
  input  logic       q_valid,
  output logic       q_ready,
  input  item_t      q_item,
  output logic       out_valid,
  input  logic       out_ready,
  output status_t    out_status,
  output logic [7:0] out_pixel,
  output logic       busy
);

  localparam int MB     = MAX_CODE_BITS;
  localparam int SW     = MAX_CODE_BITS + 1;
  localparam int TBL_N  = 1 << MAX_CODE_BITS;
  localparam logic [SW-1:0] TBL = SW'(TBL_N);

  state_t            state_r, state_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [3:0]        cw_r, cw_nxt, amin_r, amin_nxt;
  logic [SW-1:0]     nf_r, nf_nxt, wl_r, wl_nxt, depth_r, depth_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [MB-1:0]     prev_r, prev_nxt, incode_r, incode_nxt, cur_r, cur_nxt;
  logic [MB-1:0]     idx_r, idx_nxt;
  logic              fresh_r, fresh_nxt, ended_r, ended_nxt;
  logic              ovalid_r, ovalid_nxt;
  status_t           ostat_r, ostat_nxt;
  logic [7:0]        opix_r, opix_nxt;

  logic              stk_we, tbl_we;
  logic [MB-1:0]     stk_waddr, stk_raddr, tbl_raddr;
  logic [7:0]        stk_wdata, stk_rdata, suf_rdata;
  logic [MB-1:0]     pre_rdata;

  logic [SW-1:0]     clr, code_z, nf_inc;
  logic [BUF_W-1:0]  code_full;
  logic [MB-1:0]     code, pre;
  logic [7:0]        suf;
  logic              have, written, out_free;
  status_t           short_st;
  logic [3:0]        m;

  assign clr       = SW'(1) << amin_r;
  assign code_full = buf_r & ((BUF_W'(1) << cw_r) - BUF_W'(1));
  assign code      = code_full[MB-1:0];
  assign code_z    = {1'b0, code};
  assign have      = held_r >= {1'b0, cw_r};
  assign short_st  = !ended_r ? ST_NEED : (held_r != '0) ? ST_ENDDATA : ST_ERROR;
  assign out_free  = !ovalid_r || out_ready;
  assign written   = ({1'b0, idx_r} >= clr + SW'(2)) && ({1'b0, idx_r} < nf_r);
  assign pre       = written ? pre_rdata : '0;
  assign suf       = ({1'b0, idx_r} < clr) ? idx_r[7:0] : (written ? suf_rdata : 8'd0);
  assign nf_inc    = nf_r + SW'(1);
  assign q_ready   = (state_r == S_IDLE) && out_free;
  assign busy      = (state_r != S_IDLE);

  always_comb begin
    m = min_code_size;
    if (m < 4'd2) m = 4'd2;
    if (m > 4'd8) m = 4'd8;
  end

  always_comb begin
    state_nxt  = state_r;
    buf_nxt    = buf_r;
    held_nxt   = held_r;
    cw_nxt     = cw_r;
    amin_nxt   = amin_r;
    nf_nxt     = nf_r;
    wl_nxt     = wl_r;
    depth_nxt  = depth_r;
    first_nxt  = first_r;
    prev_nxt   = prev_r;
    incode_nxt = incode_r;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    fresh_nxt  = fresh_r;
    ended_nxt  = ended_r;
    ovalid_nxt = ovalid_r && !out_ready;
    ostat_nxt  = ostat_r;
    opix_nxt   = opix_r;
    stk_we     = 1'b0;
    stk_waddr  = depth_r[MB-1:0];
    stk_wdata  = suf;
    stk_raddr  = depth_r[MB-1:0] - MB'(1);
    tbl_we     = 1'b0;
    tbl_raddr  = cur_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          case (q_item.cmd)
            CMD_START: begin
              amin_nxt   = m;
              cw_nxt     = m + 4'd1;
              nf_nxt     = (SW'(1) << m) + SW'(2);
              wl_nxt     = SW'(2) << m;
              depth_nxt  = '0;
              buf_nxt    = '0;
              held_nxt   = '0;
              ended_nxt  = 1'b0;
              fresh_nxt  = 1'b1;
              ovalid_nxt = 1'b1;
              ostat_nxt  = ST_NEED;
              opix_nxt   = 8'd0;
            end
            CMD_FEED: begin
              ovalid_nxt = 1'b1;
              opix_nxt   = 8'd0;
              if (held_r > HELD_W'(16)) begin
                ostat_nxt = ST_FULL;
              end else begin
                buf_nxt   = buf_r | (BUF_W'(q_item.data_byte) << held_r);
                held_nxt  = held_r + HELD_W'(8);
                ostat_nxt = ST_TAKEN;
              end
            end
            CMD_END: begin
              ended_nxt  = 1'b1;
              ovalid_nxt = 1'b1;
              ostat_nxt  = ST_ENDDATA;
              opix_nxt   = 8'd0;
            end
            default: begin
              if (fresh_r) begin
                state_nxt = S_FIRST;
              end else if (depth_r != '0) begin
                depth_nxt = depth_r - SW'(1);
                state_nxt = S_POP;
              end else if (!have) begin
                ovalid_nxt = 1'b1;
                ostat_nxt  = short_st;
                opix_nxt   = 8'd0;
              end else begin
                buf_nxt  = buf_r >> cw_r;
                held_nxt = held_r - HELD_W'(cw_r);
                if (code_z == clr) begin
                  cw_nxt    = amin_r + 4'd1;
                  nf_nxt    = clr + SW'(2);
                  wl_nxt    = clr << 1;
                  depth_nxt = '0;
                  fresh_nxt = 1'b1;
                  state_nxt = S_FIRST;
                end else if (code_z == clr + SW'(1)) begin
                  ovalid_nxt = 1'b1;
                  ostat_nxt  = ST_ENDCODE;
                  opix_nxt   = 8'd0;
                end else begin
                  incode_nxt = code;
                  if (code_z >= nf_r) begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = first_r;
                    depth_nxt = SW'(1);
                    cur_nxt   = prev_r;
                  end else begin
                    cur_nxt = code;
                  end
                  state_nxt = S_WALK_RD;
                end
              end
            end
          endcase
        end
      end
      S_FIRST: begin
        state_nxt = S_IDLE;
        opix_nxt  = 8'd0;
        if (!have) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = short_st;
        end else begin
          buf_nxt  = buf_r >> cw_r;
          held_nxt = held_r - HELD_W'(cw_r);
          if (code_z == clr) begin
            state_nxt = S_FIRST;
          end else if (code_z == clr + SW'(1)) begin
            ovalid_nxt = 1'b1;
            ostat_nxt  = ST_ENDCODE;
          end else if (code_z >= clr + SW'(2)) begin
            ovalid_nxt = 1'b1;
            ostat_nxt  = ST_ERROR;
          end else begin
            fresh_nxt  = 1'b0;
            first_nxt  = code[7:0];
            prev_nxt   = code;
            ovalid_nxt = 1'b1;
            ostat_nxt  = ST_PIXEL;
            opix_nxt   = code[7:0];
          end
        end
      end
      S_POP: begin
        ovalid_nxt = 1'b1;
        ostat_nxt  = ST_PIXEL;
        opix_nxt   = stk_rdata;
        state_nxt  = S_IDLE;
      end
      S_WALK_RD: begin
        if ({1'b0, cur_r} >= clr) begin
          idx_nxt   = cur_r;
          state_nxt = S_WALK_USE;
        end else begin
          first_nxt  = cur_r[7:0];
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
          if (depth_r >= TBL) begin
            depth_nxt = '0;
            ostat_nxt = ST_ERROR;
            opix_nxt  = 8'd0;
          end else begin
            if (nf_r < TBL) begin
              tbl_we = 1'b1;
              nf_nxt = nf_inc;
              if (nf_inc >= wl_r && wl_r < TBL) begin
                wl_nxt = wl_r << 1;
                cw_nxt = cw_r + 4'd1;
              end
            end
            prev_nxt  = incode_r;
            ostat_nxt = ST_PIXEL;
            opix_nxt  = cur_r[7:0];
          end
        end
      end
      S_WALK_USE: begin
        if (depth_r >= TBL) begin
          depth_nxt  = '0;
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_ERROR;
          opix_nxt   = 8'd0;
          state_nxt  = S_IDLE;
        end else begin
          stk_we = 1'b1;
          if (pre == idx_r) begin
            depth_nxt  = '0;
            ovalid_nxt = 1'b1;
            ostat_nxt  = ST_ERROR;
            opix_nxt   = 8'd0;
            state_nxt  = S_IDLE;
          end else begin
            depth_nxt = depth_r + SW'(1);
            cur_nxt   = pre;
            state_nxt = S_WALK_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      buf_r    <= '0;
      held_r   <= '0;
      amin_r   <= 4'd8;
      cw_r     <= 4'd9;
      nf_r     <= SW'(258);
      wl_r     <= SW'(512);
      depth_r  <= '0;
      first_r  <= '0;
      prev_r   <= '0;
      fresh_r  <= 1'b0;
      ended_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      buf_r    <= buf_nxt;
      held_r   <= held_nxt;
      amin_r   <= amin_nxt;
      cw_r     <= cw_nxt;
      nf_r     <= nf_nxt;
      wl_r     <= wl_nxt;
      depth_r  <= depth_nxt;
      first_r  <= first_nxt;
      prev_r   <= prev_nxt;
      fresh_r  <= fresh_nxt;
      ended_r  <= ended_nxt;
      ovalid_r <= ovalid_nxt;
    end
    incode_r <= incode_nxt;
    cur_r    <= cur_nxt;
    idx_r    <= idx_nxt;
    ostat_r  <= ostat_nxt;
    opix_r   <= opix_nxt;
  end

  assign out_valid  = ovalid_r;
  assign out_status = ostat_r;
  assign out_pixel  = opix_r;

  gll_ram #(.WIDTH(8), .DEPTH(TBL_N)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  gll_ram #(.WIDTH(MB), .DEPTH(TBL_N)) u_prefix (
    .clk(clk), .we(tbl_we), .waddr(nf_r[MB-1:0]), .wdata(prev_r),
    .raddr(tbl_raddr), .rdata(pre_rdata)
  );

  gll_ram #(.WIDTH(8), .DEPTH(TBL_N)) u_suffix (
    .clk(clk), .we(tbl_we), .waddr(nf_r[MB-1:0]), .wdata(cur_r[7:0]),
    .raddr(tbl_raddr), .rdata(suf_rdata)
  );

endmodule

[sv/gif_lzw_pixel_decoder.sv]
// GIF LZW pixel decoder top level.
// Requests enter a two-item queue and the core answers each with one result.
// Start, feed and end-of-data requests are answered from the idle state; a fetch
// that pops the output stack reads the stack RAM first; a fetch that reads a
// new code walks the prefix chain through the table RAMs link by link; a fetch
// right after start, or one that reads a clear code, then reads codes in the
// first-code state, skipping any further clear codes.
// The tables need no clearing pass: entries at or above the next free code
// read as zero.
module gif_lzw_pixel_decoder import gll_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] pixel
  output logic [2:0] out_tuser,  // [2:0] status
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  logic       cfg_we;
  logic [3:0] min_code_size_r;
  logic       q_valid, q_ready, busy;
  item_t      q_item;
  status_t    status;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_code_size_r <= 4'd8;
    end else if (cfg_we) begin
      min_code_size_r <= cfg_data;
    end
  end

  gll_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_kind(in_tuser), .in_byte(in_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  gll_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .min_code_size(min_code_size_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(status), .out_pixel(out_tdata), .busy(busy)
  );

  assign out_tuser = status;

`ifndef ASSERT_OFF
  a_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_PIXEL) |-> out_tdata == 8'd0)
    else $error("non-pixel result with nonzero pixel");
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_tvalid)
    else $error("result pending while core busy");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !q_ready)
    else $error("queue popped while core busy");
`endif

endmodule

[tb/testbench.sv]
// Testbench for the GIF LZW pixel decoder: stream stimulus, scoreboard with decoder model.
`timescale 1ns / 100ps

class lzw_scoreboard;
  bit [11:0] prefix_tbl [4096];
  bit [7:0]  suffix_tbl [4096];
  bit [7:0]  pix_stack [4096];
  int unsigned stk_depth, bitbuf, nbits, cwidth, free_code, wlimit, first_sym, prev_code;
  int unsigned min_reg, min_act;
  bit fresh, ended;
  bit [2:0] exp_status [$];
  bit [7:0] exp_pixel [$];
  int errors, results, pixels, errs_seen;

  function void rebuild();
    int unsigned clr;
    clr = 1 << min_act;
    for (int i = 0; i < 4096; i++) begin
      prefix_tbl[i] = 0;
      suffix_tbl[i] = (i < clr) ? i[7:0] : 8'd0;
    end
    cwidth = min_act + 1;
    free_code = clr + 2;
    wlimit = 2 * clr;
    stk_depth = 0;
  endfunction

  function void reset_state();
    min_reg = 8;
    min_act = 8;
    rebuild();
    bitbuf = 0; nbits = 0; first_sym = 0; prev_code = 0;
    fresh = 0; ended = 0;
  endfunction

  function int grab_code(output int unsigned code);
    code = 0;
    if (nbits < cwidth) begin
      if (!ended) return gll_pkg::ST_NEED;
      return nbits > 0 ? gll_pkg::ST_ENDDATA : gll_pkg::ST_ERROR;
    end
    code = bitbuf & ((1 << cwidth) - 1);
    bitbuf = (bitbuf >> cwidth) & 24'hFFFFFF;
    nbits -= cwidth;
    return -1;
  endfunction

  function int decode_first(output int unsigned pix);
    int unsigned clr, c;
    int st;
    clr = 1 << min_act;
    pix = 0;
    forever begin
      st = grab_code(c);
      if (st >= 0) return st;
      if (c == clr) continue;
      if (c == clr + 1) return gll_pkg::ST_ENDCODE;
      if (c >= clr + 2) return gll_pkg::ST_ERROR;
      fresh = 0;
      first_sym = c & 8'hFF;
      prev_code = c;
      pix = c & 8'hFF;
      return gll_pkg::ST_PIXEL;
    end
  endfunction

  function bit push(int unsigned s);
    if (stk_depth >= 4096) return 0;
    pix_stack[stk_depth] = s[7:0];
    stk_depth++;
    return 1;
  endfunction

  function int decode_pixel(output int unsigned pix);
    int unsigned clr, code, incode;
    int st;
    clr = 1 << min_act;
    pix = 0;
    if (fresh) return decode_first(pix);
    if (stk_depth > 0) begin
      stk_depth--;
      pix = pix_stack[stk_depth];
      return gll_pkg::ST_PIXEL;
    end
    st = grab_code(code);
    if (st >= 0) return st;
    if (code == clr) begin
      rebuild();
      fresh = 1;
      return decode_first(pix);
    end
    if (code == clr + 1) return gll_pkg::ST_ENDCODE;
    incode = code;
    if (code >= free_code) begin
      if (!push(first_sym)) begin stk_depth = 0; return gll_pkg::ST_ERROR; end
      code = prev_code;
    end
    while (code >= clr) begin
      code &= 4095;
      if (!push(suffix_tbl[code]) || prefix_tbl[code] == code) begin
        stk_depth = 0;
        return gll_pkg::ST_ERROR;
      end
      code = prefix_tbl[code];
    end
    first_sym = suffix_tbl[code & 4095];
    if (!push(first_sym)) begin stk_depth = 0; return gll_pkg::ST_ERROR; end
    if (free_code < 4096) begin
      prefix_tbl[free_code] = prev_code[11:0];
      suffix_tbl[free_code] = first_sym[7:0];
      free_code++;
      if (free_code >= wlimit && wlimit < 4096) begin
        wlimit *= 2;
        cwidth++;
      end
    end
    prev_code = incode;
    stk_depth--;
    pix = pix_stack[stk_depth];
    return gll_pkg::ST_PIXEL;
  endfunction

  function void note_config(bit [3:0] v);
    min_reg = v;
  endfunction

  function void note_item(gll_pkg::cmd_t kind, bit [7:0] b);
    int st;
    int unsigned pix, m;
    pix = 0;
    case (kind)
      gll_pkg::CMD_START: begin
        m = min_reg;
        if (m < 2) m = 2;
        if (m > 8) m = 8;
        min_act = m;
        rebuild();
        bitbuf = 0; nbits = 0; ended = 0; fresh = 1;
        st = gll_pkg::ST_NEED;
      end
      gll_pkg::CMD_FEED: begin
        if (nbits > 16) st = gll_pkg::ST_FULL;
        else begin
          bitbuf = (bitbuf | (b << nbits)) & 24'hFFFFFF;
          nbits += 8;
          st = gll_pkg::ST_TAKEN;
        end
      end
      gll_pkg::CMD_END: begin
        ended = 1;
        st = gll_pkg::ST_ENDDATA;
      end
      default: st = decode_pixel(pix);
    endcase
    exp_status.push_back(st[2:0]);
    exp_pixel.push_back(st == gll_pkg::ST_PIXEL ? pix[7:0] : 8'd0);
  endfunction

  function void check_result(bit [2:0] status, bit [7:0] pixel);
    bit [2:0] es;
    bit [7:0] ep;
    results++;
    if (exp_status.size() == 0) begin
      $error("unexpected item: status %0d pixel %0d", status, pixel);
      errors++;
      return;
    end
    es = exp_status.pop_front();
    ep = exp_pixel.pop_front();
    if (es == gll_pkg::ST_PIXEL) pixels++;
    if (es == gll_pkg::ST_ERROR) errs_seen++;
    if (status !== es) begin
      $error("status: expected %0d, actual %0d", es, status);
      errors++;
    end
    if (pixel !== ep) begin
      $error("pixel: expected %0d, actual %0d", ep, pixel);
      errors++;
    end
  endfunction
endclass

module testbench;
  import gll_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic [1:0] in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  lzw_scoreboard sb;
  int hold_off;
  int sent;

  gif_lzw_pixel_decoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("testbench: FAIL");
    $finish;
  end

  // receiver: stall pattern plus optional long hold-off
  initial begin
    int phase;
    phase = 0;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      phase++;
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 0;
      end else if ((phase / 64) % 3 == 0) out_tready <= 1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send(cmd_t k, bit [7:0] b);
    in_tvalid <= 1;
    in_tuser <= k;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(k, b);
    sent++;
    if ($urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(bit [3:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(v);
    cfg_valid <= 0;
  endtask

  // codes packed LSB first into bytes; feeds bytes as they complete
  int unsigned pk_buf, pk_n;
  task automatic put_code(int unsigned code, int unsigned w);
    pk_buf |= code << pk_n;
    pk_n += w;
    while (pk_n >= 8) begin
      send(CMD_FEED, pk_buf[7:0]);
      pk_buf >>= 8;
      pk_n -= 8;
    end
  endtask

  // stream: clear, codes tracking width, fetches interleaved; broken mixes in random codes
  task automatic run_stream(int unsigned msz, int ncodes, bit broken);
    int unsigned clr, nxt, w, c, m;
    m = msz < 2 ? 2 : (msz > 8 ? 8 : msz);
    clr = 1 << m;
    nxt = clr + 2;
    w = m + 1;
    pk_buf = 0; pk_n = 0;
    send(CMD_START, 8'($urandom));
    put_code(clr, w);
    for (int i = 0; i < ncodes; i++) begin
      if (i == 0) c = $urandom_range(0, clr - 1);
      else if (broken && $urandom_range(0, 9) == 0) c = $urandom_range(0, (1 << w) - 1);
      else if ($urandom_range(0, 3) == 0) c = nxt;
      else if ($urandom_range(0, 2) == 0 && nxt > clr + 2) c = $urandom_range(clr + 2, nxt - 1);
      else c = $urandom_range(0, clr - 1);
      put_code(c, w);
      if (i > 0 && nxt < 4096) begin
        nxt++;
        if (nxt >= (1 << w) && w < 12) w++;
      end
      repeat ($urandom_range(1, 3)) send(CMD_FETCH, 0);
    end
    put_code(clr + 1, w);
    if (pk_n > 0) send(CMD_FEED, pk_buf[7:0]);
    send(CMD_END, 0);
    repeat ($urandom_range(4, 12)) send(CMD_FETCH, 0);
  endtask

  initial begin
    int unsigned sizes [6];
    sizes = '{2, 8, 0, 15, 5, 3};
    sb = new();
    sb.reset_state();
    hold_off = 0;
    sent = 0;
    rst_n = 0;
    in_tvalid = 0; in_tdata = 0; in_tuser = CMD_START;
    cfg_valid = 0; cfg_data = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: fetch before start, extremes, overfill, end-of-data cases
    send(CMD_FETCH, 0);
    send(CMD_START, 8'hFF);
    send(CMD_FETCH, 0);
    send(CMD_FEED, 8'h00);
    send(CMD_FEED, 8'hFF);
    send(CMD_FEED, 8'hAA);
    send(CMD_FEED, 8'h55);
    send(CMD_FETCH, 0);
    send(CMD_FETCH, 0);
    send(CMD_FETCH, 0);
    send(CMD_END, 0);
    send(CMD_FETCH, 0);
    send(CMD_FETCH, 0);
    send(CMD_FETCH, 0);
    drain();
    write_cfg(4'd2);
    pk_buf = 0; pk_n = 0;
    send(CMD_START, 0);
    put_code(4, 3); put_code(4, 3); put_code(6, 3); put_code(1, 3);
    put_code(6, 3); put_code(7, 3); put_code(3, 3); put_code(5, 3);
    if (pk_n > 0) send(CMD_FEED, pk_buf[7:0]);
    repeat (8) send(CMD_FETCH, 0);
    drain();

    // long receiver hold-off while input keeps coming
    hold_off = 300;
    foreach (sizes[i]) begin
      write_cfg(sizes[i]);
      for (int r = 0; r < 2; r++) run_stream(sizes[i], $urandom_range(3, 8), r == 1);
      repeat (6) send(cmd_t'($urandom_range(0, 3)), 8'($urandom));
      drain();
    end
    write_cfg(4'($urandom));
    run_stream(sb.min_reg, 15, 0);
    drain();

    $display("Summary: %0d items sent, %0d results checked, %0d pixels, %0d error codes.",
             sent, sb.results, sb.pixels, sb.errs_seen);
    if (sb.errors == 0 && sb.exp_status.size() == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
